FILE: rtl/mprb_pkg.sv
// ============================================================================
// mprb_pkg
// Shared types and constants of the multi-pipe ring buffer engine.
// ============================================================================
package mprb_pkg;

    localparam int DEF_NUM_PIPES = 16;
    localparam int DEF_BUF_DEPTH = 256;

    localparam int CMD_W     = 2;
    localparam int FD_W      = 8;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int FD_BASE_W = 5;

    // Input tdata: fd, write_byte. Output tdata: status, read_byte, fd_base.
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLOSE  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BADFD     = 2'd1,
        ST_FULLEMPTY = 2'd2,
        ST_NOFREE    = 2'd3
    } t_status;

    // One finished result, held until the output register takes it.
    typedef struct packed {
        t_status                status;
        logic [BYTE_W-1:0]      read_byte;
        logic [FD_BASE_W-1:0]   fd_base;
        logic                   last;
    } t_result;

endpackage

FILE: rtl/mprb_ptr_mem.sv
// ============================================================================
// mprb_ptr_mem
// Per-pipe pointer table (head, tail, fill level): one write port, one
// registered read port.
// ============================================================================
module mprb_ptr_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 25,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/mprb_byte_mem.sv
// ============================================================================
// mprb_byte_mem
// Byte store shared by all pipes: one write port, one registered read port.
// ============================================================================
module mprb_byte_mem
    import mprb_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/multi_pipe_ring_buffer_engine_unit.sv
// ============================================================================
// multi_pipe_ring_buffer_engine_unit
// Command engine for a set of byte pipes kept as ring buffers in memory.
// ============================================================================
// Usage:
//   Slave stream carries one command per item: tuser = cmd (create, write,
//   read, close), tdata = fd (bits 7:0) and write_byte (bits 15:8), tlast =
//   last_byte. Every command yields exactly one result item on the master
//   stream: tdata = status (1:0), read_byte (9:2), fd_base (14:10), and tlast
//   echoes last_byte.
//   A create claims the lowest free pipe and returns its read-end descriptor;
//   write (odd fd) appends a byte, read (even fd) takes one, close frees the
//   pipe from either end. Errors report a status and change nothing.
//   Flow: one item is in flight at a time. Accept, then the pointer table
//   read, then the byte store read on a read command, then the load of the
//   output register, which waits while the master side stalls.
//   Reset clears the busy flags, the state machine and the output valid; the
//   memories need no clearing since a pipe's entries are rewritten by create.
//   When the master side stalls, the finished result waits in a staging
//   register; no new item is taken until it moves to the output register.
// ============================================================================
module multi_pipe_ring_buffer_engine_unit
    import mprb_pkg::*;
#(
    parameter int NUM_PIPES = DEF_NUM_PIPES,
    parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // fd [7:0], write_byte [15:8]
    input  logic [CMD_W-1:0]      s_axis_tuser,   // cmd [1:0]
    input  logic                  s_axis_tlast,   // last_byte
    // master side
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // status [1:0], read_byte [9:2],
                                                  // fd_base [14:10], zero [15]
    output logic                  m_axis_tlast    // last
);

    localparam int PIW   = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int PW    = $clog2(BUF_DEPTH);
    localparam int FW    = $clog2(BUF_DEPTH + 1);
    localparam int ENT_W = 2 * PW + FW;
    localparam int BDEP  = NUM_PIPES * BUF_DEPTH;
    localparam int BAW   = (BDEP > 1) ? $clog2(BDEP) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_FETCH = 4'b0100,
        S_PUSH  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Captured command.
    t_cmd              r_cmd;
    logic [FD_W-1:0]   r_fd;
    logic [BYTE_W-1:0] r_wbyte;
    logic              r_last;
    logic [PIW-1:0]    r_pidx;
    logic              r_idx_ok;
    logic [BAW-1:0]    r_base;

    // Busy flags and lowest free pipe.
    logic [NUM_PIPES-1:0] r_busy, n_busy;
    logic [PIW-1:0]       r_free_idx, free_idx;
    logic                 r_free_any, free_any;

    // Result staging and output register.
    t_result r_res, n_res;
    t_result r_out;
    logic    r_out_valid;

    // Memory ports.
    logic             ptr_wr_en;
    logic [PIW-1:0]   ptr_wr_addr;
    logic [ENT_W-1:0] ptr_wr_data;
    logic [ENT_W-1:0] ptr_rd_data;
    logic             ptr_rd_en;
    logic             byte_wr_en;
    logic             byte_rd_en;
    logic [BAW-1:0]   byte_wr_addr;
    logic [BAW-1:0]   byte_rd_addr;
    logic [BYTE_W-1:0] byte_rd_data;

    logic [PW-1:0] head, tail, head_next, tail_next;
    logic [FW-1:0] fill, wr_fill;
    logic          pipe_ok;
    logic          accept;
    logic          push;
    logic [PIW-1:0] in_pidx;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign push          = (r_state == S_PUSH) && (!r_out_valid || m_axis_tready);
    assign in_pidx       = s_axis_tdata[PIW:1];

    // Issue the pointer table read as the item is taken.
    assign ptr_rd_en = accept;

    // Lowest free pipe, registered from the busy flags.
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = NUM_PIPES - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_idx = PIW'(i);
                free_any = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_idx <= free_idx;
        r_free_any <= free_any;
    end

    // Unpack the pointer entry and work out the next positions.
    assign {head, tail, fill} = ptr_rd_data;
    assign head_next = (head == PW'(BUF_DEPTH - 1)) ? '0 : head + PW'(1);
    assign tail_next = (tail == PW'(BUF_DEPTH - 1)) ? '0 : tail + PW'(1);
    assign pipe_ok   = r_idx_ok && r_busy[r_pidx];
    assign wr_fill   = ptr_wr_data[FW-1:0];

    assign byte_wr_addr = r_base + BAW'(tail);
    assign byte_rd_addr = r_base + BAW'(head);

    // Next-state logic and command decode in the execute cycle.
    always_comb begin
        n_state      = r_state;
        n_busy       = r_busy;
        n_res        = r_res;
        ptr_wr_en    = 1'b0;
        ptr_wr_addr  = r_pidx;
        ptr_wr_data  = {head, tail, fill};
        byte_wr_en   = 1'b0;
        byte_rd_en   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res.status    = ST_OK;
                n_res.read_byte = '0;
                n_res.fd_base   = '0;
                n_res.last      = r_last;
                n_state         = S_PUSH;
                case (r_cmd)
                    CMD_CREATE: begin
                        if (r_free_any) begin
                            n_busy[r_free_idx] = 1'b1;
                            ptr_wr_en          = 1'b1;
                            ptr_wr_addr        = r_free_idx;
                            ptr_wr_data        = '0;
                            n_res.fd_base      = FD_BASE_W'({r_free_idx, 1'b0});
                        end else begin
                            n_res.status = ST_NOFREE;
                        end
                    end
                    CMD_CLOSE: begin
                        if (pipe_ok) begin
                            n_busy[r_pidx] = 1'b0;
                        end else begin
                            n_res.status = ST_BADFD;
                        end
                    end
                    CMD_WRITE: begin
                        if (!pipe_ok || !r_fd[0]) begin
                            n_res.status = ST_BADFD;
                        end else if (fill == FW'(BUF_DEPTH)) begin
                            n_res.status = ST_FULLEMPTY;
                        end else begin
                            byte_wr_en  = 1'b1;
                            ptr_wr_en   = 1'b1;
                            ptr_wr_data = {head, tail_next, fill + FW'(1)};
                        end
                    end
                    CMD_READ: begin
                        if (!pipe_ok || r_fd[0]) begin
                            n_res.status = ST_BADFD;
                        end else if (fill == '0) begin
                            n_res.status = ST_FULLEMPTY;
                        end else begin
                            byte_rd_en  = 1'b1;
                            ptr_wr_en   = 1'b1;
                            ptr_wr_data = {head_next, tail, fill - FW'(1)};
                            n_state     = S_FETCH;
                        end
                    end
                    default: begin
                        n_res.status = ST_BADFD;
                    end
                endcase
            end
            S_FETCH: begin
                n_res.read_byte = byte_rd_data;
                n_state         = S_PUSH;
            end
            S_PUSH: begin
                if (push) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: capture the command, hold the result, load the output.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= t_cmd'(s_axis_tuser);
            r_fd     <= s_axis_tdata[FD_W-1:0];
            r_wbyte  <= s_axis_tdata[FD_W +: BYTE_W];
            r_last   <= s_axis_tlast;
            r_pidx   <= in_pidx;
            r_idx_ok <= (int'(s_axis_tdata[FD_W-1:1]) < NUM_PIPES);
            r_base   <= BAW'(BAW'(in_pidx) * BAW'(BUF_DEPTH));
        end
        r_res <= n_res;
        if (push) begin
            r_out <= r_res;
        end
    end

    mprb_ptr_mem #(
        .DEPTH  (NUM_PIPES),
        .WIDTH  (ENT_W),
        .ADDR_W (PIW)
    ) u_ptr_mem (
        .i_clk     (i_clk),
        .i_wr_en   (ptr_wr_en),
        .i_wr_addr (ptr_wr_addr),
        .i_wr_data (ptr_wr_data),
        .i_rd_en   (ptr_rd_en),
        .i_rd_addr (in_pidx),
        .o_rd_data (ptr_rd_data)
    );

    mprb_byte_mem #(
        .DEPTH  (BDEP),
        .ADDR_W (BAW)
    ) u_byte_mem (
        .i_clk     (i_clk),
        .i_wr_en   (byte_wr_en),
        .i_wr_addr (byte_wr_addr),
        .i_wr_data (r_wbyte),
        .i_rd_en   (byte_rd_en),
        .i_rd_addr (byte_rd_addr),
        .o_rd_data (byte_rd_data)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.fd_base, r_out.read_byte, r_out.status};
    assign m_axis_tlast  = r_out.last;

    // A byte fetch cycle always follows a byte store read.
    a_fetch_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> $past(byte_rd_en))
        else $error("byte fetch without store read");

    // The output only becomes valid from a push.
    a_out_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_PUSH))
        else $error("output valid without push");

    // A successful create marks the claimed pipe busy.
    a_create_claims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && (r_cmd == CMD_CREATE) && r_free_any)
            |=> r_busy[$past(r_free_idx)])
        else $error("created pipe not marked busy");

    // The fill level written back never exceeds the buffer depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ptr_wr_en |-> (wr_fill <= FW'(BUF_DEPTH)))
        else $error("fill level overflow");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Testbench for the multi-pipe ring buffer engine. It drives commands on the
// slave stream, keeps its own model of the pipe table and byte store, and
// checks each result item on the master stream against that model, field by
// field and in order. Directed tests cover the error codes, wrong ends, pipe
// exhaustion, a full pipe and pointer wrap; random traffic follows, first
// with idle bursts on both streams and then at full rate.
// ============================================================================
module tb_top;
    import mprb_pkg::*;

    localparam int PIPES      = DEF_NUM_PIPES;
    localparam int DEPTH      = DEF_BUF_DEPTH;
    localparam int STALL_LIMIT = 2000;   // cycles with no item moving
    localparam int DRAIN_WAIT  = 8;      // extra cycles after the last result
    localparam int PRINT_LIMIT = 50;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // fd [7:0], write_byte [15:8]
    logic [CMD_W-1:0]      s_axis_tuser = '0;   // cmd [1:0]
    logic                  s_axis_tlast = 1'b0; // last_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // status [1:0], read_byte [9:2],
                                                // fd_base [14:10], zero [15]
    logic                  m_axis_tlast;        // last

    // Model of the engine state
    logic                  pipe_busy [PIPES];
    logic [7:0]            head_pos  [PIPES];
    logic [7:0]            tail_pos  [PIPES];
    logic [8:0]            fill_cnt  [PIPES];
    logic [7:0]            byte_mem  [PIPES*DEPTH];

    t_result               expected_results [$];
    int                    mismatch_count = 0;
    int                    quiet_cycles = 0;
    bit                    idle_enable = 1'b1;
    int                    ready_hold = 0;

    multi_pipe_ring_buffer_engine_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Pipe model: apply one command to the model state, return its result.
    // ------------------------------------------------------------------------
    function automatic t_result apply_pipe_command(t_cmd cmd, logic [7:0] fd,
                                                   logic [7:0] wbyte, logic lbyte);
        t_result res;
        int      idx;
        bit      found;
        res        = '0;
        res.status = ST_OK;
        res.last   = lbyte;
        idx        = int'(fd >> 1);
        found      = 1'b0;
        if (cmd == CMD_CREATE) begin
            // claim the lowest free pipe and clear its pointers
            res.status = ST_NOFREE;
            for (int i = 0; i < PIPES; i++) begin
                if (!found && !pipe_busy[i]) begin
                    found        = 1'b1;
                    pipe_busy[i] = 1'b1;
                    head_pos[i]  = '0;
                    tail_pos[i]  = '0;
                    fill_cnt[i]  = '0;
                    res.fd_base  = FD_BASE_W'(i * 2);
                    res.status   = ST_OK;
                end
            end
        end else if (idx >= PIPES || !pipe_busy[idx]) begin
            res.status = ST_BADFD;
        end else begin
            case (cmd)
                CMD_CLOSE: begin
                    pipe_busy[idx] = 1'b0;
                end
                CMD_WRITE: begin
                    if (!fd[0]) begin
                        res.status = ST_BADFD;
                    end else if (fill_cnt[idx] >= DEPTH) begin
                        res.status = ST_FULLEMPTY;
                    end else begin
                        byte_mem[idx*DEPTH + int'(tail_pos[idx])] = wbyte;
                        tail_pos[idx] = 8'((int'(tail_pos[idx]) + 1) % DEPTH);
                        fill_cnt[idx] = fill_cnt[idx] + 9'd1;
                    end
                end
                default: begin
                    if (fd[0]) begin
                        res.status = ST_BADFD;
                    end else if (fill_cnt[idx] == 0) begin
                        res.status = ST_FULLEMPTY;
                    end else begin
                        res.read_byte = byte_mem[idx*DEPTH + int'(head_pos[idx])];
                        head_pos[idx] = 8'((int'(head_pos[idx]) + 1) % DEPTH);
                        fill_cnt[idx] = fill_cnt[idx] - 9'd1;
                    end
                end
            endcase
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // ------------------------------------------------------------------------
    // Send one command item. Call right after a rising edge. Holds tvalid
    // high after acceptance so back-to-back items need no extra step.
    // ------------------------------------------------------------------------
    task automatic send_cmd(t_cmd cmd, logic [7:0] fd, logic [7:0] wbyte,
                            logic lbyte, output t_result res);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {wbyte, fd};
        s_axis_tlast  <= lbyte;
        do @(posedge i_clk); while (!s_axis_tready);
        res = apply_pipe_command(cmd, fd, wbyte, lbyte);
        expected_results.push_back(res);
    endtask

    task automatic send(t_cmd cmd, logic [7:0] fd, logic [7:0] wbyte, logic lbyte);
        t_result res;
        send_cmd(cmd, fd, wbyte, lbyte, res);
    endtask

    // ------------------------------------------------------------------------
    // Master side: stall in random bursts while idling is enabled.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (idle_enable && i_rst_n && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            ready_hold    <= int'($urandom_range(1, 7)) - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata=%h tlast=%b",
                                          m_axis_tdata, m_axis_tlast));
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[1:0] != want.status)
                    report_mismatch($sformatf("status: got %0d want %0d",
                                              m_axis_tdata[1:0], want.status));
                if (m_axis_tdata[9:2] != want.read_byte)
                    report_mismatch($sformatf("read_byte: got %h want %h",
                                              m_axis_tdata[9:2], want.read_byte));
                if (m_axis_tdata[14:10] != want.fd_base)
                    report_mismatch($sformatf("fd_base: got %0d want %0d",
                                              m_axis_tdata[14:10], want.fd_base));
                if (m_axis_tdata[15] !== 1'b0)
                    report_mismatch("tdata pad bit is not zero");
                if (m_axis_tlast != want.last)
                    report_mismatch($sformatf("last: got %b want %b",
                                              m_axis_tlast, want.last));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("** multi_pipe_ring_buffer_engine_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Error codes, wrong ends, close from either end, lowest-free reuse.
    task automatic test_basic_commands();
        send(CMD_READ,   8'd0,   8'h00, 1'b0);  // unused pipe
        send(CMD_WRITE,  8'd255, 8'hFF, 1'b1);  // index far out of range
        send(CMD_CLOSE,  8'd32,  8'h5A, 1'b0);  // first index past the table
        send(CMD_CREATE, 8'd0,   8'h00, 1'b0);  // pipe 0
        send(CMD_CREATE, 8'd0,   8'h00, 1'b1);  // pipe 1
        send(CMD_WRITE,  8'd0,   8'h11, 1'b0);  // write on read end
        send(CMD_READ,   8'd1,   8'h22, 1'b0);  // read on write end
        send(CMD_READ,   8'd0,   8'h00, 1'b0);  // empty
        send(CMD_WRITE,  8'd1,   8'hFF, 1'b1);
        send(CMD_WRITE,  8'd1,   8'h00, 1'b0);
        send(CMD_WRITE,  8'd3,   8'hA5, 1'b1);
        send(CMD_READ,   8'd0,   8'h00, 1'b1);
        send(CMD_READ,   8'd0,   8'hFF, 1'b0);
        send(CMD_READ,   8'd0,   8'h00, 1'b0);  // drained
        send(CMD_CLOSE,  8'd3,   8'h00, 1'b0);  // close by write end
        send(CMD_WRITE,  8'd3,   8'h33, 1'b0);  // now unused
        send(CMD_READ,   8'd2,   8'h00, 1'b0);
        send(CMD_CREATE, 8'd7,   8'h00, 1'b0);  // reuses pipe 1
        send(CMD_READ,   8'd2,   8'h00, 1'b1);  // old byte unreachable
        send(CMD_CLOSE,  8'd0,   8'h00, 1'b0);  // close by read end
        send(CMD_CLOSE,  8'd2,   8'h00, 1'b1);
        send(CMD_CLOSE,  8'd0,   8'h00, 1'b0);  // already closed
        send(CMD_CREATE, 8'd255, 8'hFF, 1'b1);  // ignored fields at max
        send(CMD_CLOSE,  8'd1,   8'h00, 1'b0);
    endtask

    // Claim every pipe, overflow the table, use the top pipe, release all.
    task automatic test_pipe_exhaustion();
        for (int i = 0; i <= PIPES; i++) begin
            send(CMD_CREATE, 8'($urandom_range(0, 255)), 8'h00, 1'($urandom_range(0, 1)));
        end
        send(CMD_WRITE, 8'(PIPES*2 - 1), 8'h7E, 1'b1);
        send(CMD_READ,  8'(PIPES*2 - 2), 8'h00, 1'b0);
        for (int i = 0; i < PIPES; i++) begin
            send(CMD_CLOSE, 8'(i*2 + (i & 1)), 8'h00, 1'b0);
        end
        send(CMD_CLOSE, 8'(PIPES*2 - 2), 8'h00, 1'b0);
    endtask

    // Fill one pipe to the brim, overflow, drain past the wrap, underflow.
    task automatic test_fill_and_wrap();
        t_result res;
        logic [7:0] base;
        send_cmd(CMD_CREATE, 8'h00, 8'h00, 1'b0, res);
        base = 8'(res.fd_base);
        for (int i = 0; i < DEPTH; i++) begin
            send(CMD_WRITE, base | 8'd1, 8'($urandom_range(0, 255)),
                 1'(i == DEPTH - 1));
        end
        send(CMD_WRITE, base | 8'd1, 8'hC3, 1'b0);    // full
        for (int i = 0; i < DEPTH; i++) begin
            send(CMD_READ, base, 8'h00, 1'($urandom_range(0, 1)));
        end
        send(CMD_READ, base, 8'h00, 1'b0);            // empty
        for (int i = 0; i < 12; i++) begin
            send(CMD_WRITE, base | 8'd1, 8'($urandom_range(0, 255)), 1'b0);
            send(CMD_READ, base, 8'h00, 1'b1);
        end
        send(CMD_CLOSE, base, 8'h00, 1'b0);
    endtask

    // Mostly well-formed traffic on open pipes, with some noise commands.
    task automatic test_random_traffic(int count);
        int busy_list [$];
        int sel;
        int pick;
        logic [7:0] wbyte;
        logic lbyte;
        for (int n = 0; n < count; n++) begin
            busy_list.delete();
            for (int i = 0; i < PIPES; i++) begin
                if (pipe_busy[i]) busy_list.push_back(i);
            end
            sel   = $urandom_range(0, 99);
            wbyte = 8'($urandom_range(0, 255));
            lbyte = 1'($urandom_range(0, 1));
            if (busy_list.size() == 0 || sel < (busy_list.size() < 3 ? 12 : 3)) begin
                send(CMD_CREATE, 8'($urandom_range(0, 255)), wbyte, lbyte);
            end else begin
                pick = busy_list[$urandom_range(0, busy_list.size() - 1)];
                if (sel < 7) begin
                    send(CMD_CLOSE, 8'(pick*2 + $urandom_range(0, 1)), wbyte, lbyte);
                end else if (sel < 52) begin
                    send(CMD_WRITE, 8'(pick*2 + 1), wbyte, lbyte);
                end else if (sel < 90) begin
                    send(CMD_READ, 8'(pick*2), wbyte, lbyte);
                end else begin
                    send(t_cmd'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         wbyte, lbyte);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < PIPES; i++) begin
            pipe_busy[i] = 1'b0;
            head_pos[i]  = '0;
            tail_pos[i]  = '0;
            fill_cnt[i]  = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_commands();
        test_pipe_exhaustion();
        test_fill_and_wrap();
        test_random_traffic(160);
        // last stretch at full rate on both sides
        idle_enable = 1'b0;
        test_random_traffic(90);

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("** multi_pipe_ring_buffer_engine_unit: PASSED **");
        end else begin
            $display("** multi_pipe_ring_buffer_engine_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: multi_pipe_ring_buffer_engine_unit.f
rtl/mprb_pkg.sv
rtl/mprb_ptr_mem.sv
rtl/mprb_byte_mem.sv
rtl/multi_pipe_ring_buffer_engine_unit.sv
dv/tb_top.sv
